// ===== rtl/aldc_pkg.sv =====
// Shared types, codes and length tables of the ALDC stream decompressor.
// Used by the decoder, the output buffer and the top level; depends on nothing.
package aldc_pkg;

  typedef enum logic [2:0] {
    PH_FLAG,
    PH_LIT,
    PH_PREFIX,
    PH_LEN,
    PH_OFF
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BITS,
    ST_COPY,
    ST_FLUSH
  } seq_state_t;

  localparam logic [7:0] STOP_CODE  = 8'hFF;
  localparam logic [2:0] PREFIX_MAX = 3'd4;
  localparam logic [3:0] LIT_BITS   = 4'd8;
  localparam logic [3:0] PACK_FULL  = 4'd8;

  typedef struct packed {
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic        run_last;
    logic        stream_end;
    logic        truncated;
  } result_t;

  function automatic logic [3:0] len_width(input logic [2:0] prefix);
    logic [3:0] w;
    case (prefix)
      3'd0:    w = 4'd1;
      3'd1:    w = 4'd2;
      3'd2:    w = 4'd3;
      3'd3:    w = 4'd4;
      default: w = 4'd8;
    endcase
    return w;
  endfunction

  function automatic logic [5:0] len_base(input logic [2:0] prefix);
    logic [5:0] b;
    case (prefix)
      3'd0:    b = 6'd2;
      3'd1:    b = 6'd4;
      3'd2:    b = 6'd8;
      3'd3:    b = 6'd16;
      default: b = 6'd32;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/aldc_window.sv =====
// History window of the decompressor: one write port and one read port with
// registered read data. Write-first on a same-address collision; no package.
module aldc_window #(
  parameter int WINDOW_BITS = 10
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [WINDOW_BITS-1:0] waddr,
  input  logic [7:0]             wdata,
  input  logic                   re,
  input  logic [WINDOW_BITS-1:0] raddr,
  output logic [7:0]             rdata
);

  logic [7:0] mem [2**WINDOW_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // A copy may read the byte that is being written in the same cycle.
  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata <= wdata;
      end else begin
        rdata <= mem[raddr];
      end
    end
  end

endmodule

// ===== rtl/aldc_outbuf.sv =====
// Output register of the decompressor: holds one result transaction until the
// receiver takes it. Depends on aldc_pkg for the result type.
module aldc_outbuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  aldc_pkg::result_t result,
  output logic              free,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [63:0]       m_tdata,  // out_bytes
  output logic              m_tlast,  // run_last
  output logic [5:0]        m_tuser   // byte_count, stream_end, truncated
);

  aldc_pkg::result_t held;
  logic              valid;

  assign free     = !valid || m_tready;
  assign m_tvalid = valid;
  assign m_tdata  = held.out_bytes;
  assign m_tlast  = held.run_last;
  assign m_tuser  = {held.truncated, held.stream_end, held.byte_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (m_tready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule

// ===== rtl/aldc_decoder.sv =====
// Token parser, copy sequencer and byte packer of the decompressor. Drives the
// window memory ports and the output register. Depends on aldc_pkg.
module aldc_decoder #(
  parameter int WINDOW_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_byte,
  input  logic                   in_last,
  output logic                   mem_we,
  output logic [WINDOW_BITS-1:0] mem_waddr,
  output logic [7:0]             mem_wdata,
  output logic                   mem_re,
  output logic [WINDOW_BITS-1:0] mem_raddr,
  input  logic [7:0]             mem_rdata,
  input  logic                   out_free,
  output logic                   out_load,
  output aldc_pkg::result_t      out_result
);

  localparam int FW = (WINDOW_BITS > 8) ? WINDOW_BITS : 8;
  localparam logic [3:0] OFF_BITS = 4'(WINDOW_BITS);

  aldc_pkg::seq_state_t state, state_next;
  aldc_pkg::phase_t     phase, phase_next;

  logic [2:0]             prefix, prefix_next, prefix_inc;
  logic [FW-1:0]          field, field_next, shifted;
  logic [3:0]             bits_left, bits_left_next, bl_dec;
  logic [8:0]             copy_len, copy_len_next;
  logic                   ended, ended_next;
  logic                   marker, marker_next;
  logic [7:0]             byte_q;
  logic                   last_q;
  logic [2:0]             bit_idx;
  logic                   cur_bit;
  logic                   lit_done, copy_go;
  logic [WINDOW_BITS-1:0] wp;
  logic                   wrapped;
  logic [WINDOW_BITS-1:0] copy_src;
  logic [8:0]             copy_rem;
  logic                   rd_pend, rd_zero, unwritten;
  logic [7:0]             copy_byte;
  logic [7:0]             pack [8];
  logic [63:0]            pack_word;
  logic [3:0]             pack_cnt;
  logic                   can_take, commit, push, take, issue, copy_done, flush_emit;
  logic [7:0]             push_byte;

  assign cur_bit   = byte_q[3'd7 - bit_idx];
  assign shifted   = {field[FW-2:0], cur_bit};
  assign bl_dec    = bits_left - 4'd1;
  assign prefix_inc = prefix + {2'b00, cur_bit};
  assign copy_byte = rd_zero ? 8'h00 : mem_rdata;
  assign can_take  = (pack_cnt != aldc_pkg::PACK_FULL) || out_free;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      pack_word[8*i +: 8] = pack[i];
    end
  end

  // Effect of the current bit on the token state.
  always_comb begin
    phase_next     = phase;
    prefix_next    = prefix;
    field_next     = field;
    bits_left_next = bits_left;
    copy_len_next  = copy_len;
    ended_next     = ended;
    marker_next    = marker;
    lit_done       = 1'b0;
    copy_go        = 1'b0;
    if (!ended) begin
      case (phase)
        aldc_pkg::PH_FLAG: begin
          field_next = '0;
          if (!cur_bit) begin
            phase_next     = aldc_pkg::PH_LIT;
            bits_left_next = aldc_pkg::LIT_BITS;
          end else begin
            phase_next  = aldc_pkg::PH_PREFIX;
            prefix_next = 3'd0;
          end
        end
        aldc_pkg::PH_LIT: begin
          field_next     = FW'(shifted[7:0]);
          bits_left_next = bl_dec;
          if (bl_dec == 4'd0) begin
            lit_done   = 1'b1;
            phase_next = aldc_pkg::PH_FLAG;
          end
        end
        aldc_pkg::PH_PREFIX: begin
          prefix_next = prefix_inc;
          if (!cur_bit || (prefix_inc >= aldc_pkg::PREFIX_MAX)) begin
            if (prefix_inc > aldc_pkg::PREFIX_MAX) begin
              prefix_next = aldc_pkg::PREFIX_MAX;
            end
            phase_next     = aldc_pkg::PH_LEN;
            field_next     = '0;
            bits_left_next = aldc_pkg::len_width(prefix_next);
          end
        end
        aldc_pkg::PH_LEN: begin
          field_next     = FW'(shifted[7:0]);
          bits_left_next = bl_dec;
          if (bl_dec == 4'd0) begin
            if ((prefix >= aldc_pkg::PREFIX_MAX) && (shifted[7:0] == aldc_pkg::STOP_CODE)) begin
              ended_next  = 1'b1;
              marker_next = 1'b1;
              phase_next  = aldc_pkg::PH_FLAG;
            end else begin
              copy_len_next  = {1'b0, shifted[7:0]} + 9'(aldc_pkg::len_base(prefix));
              phase_next     = aldc_pkg::PH_OFF;
              field_next     = '0;
              bits_left_next = OFF_BITS;
            end
          end
        end
        aldc_pkg::PH_OFF: begin
          field_next     = FW'(shifted[WINDOW_BITS-1:0]);
          bits_left_next = bl_dec;
          if (bl_dec == 4'd0) begin
            copy_go    = 1'b1;
            phase_next = aldc_pkg::PH_FLAG;
            field_next = '0;
          end
        end
        default: begin
          phase_next = aldc_pkg::PH_FLAG;
        end
      endcase
    end
  end

  // Sequencer: next state, window accesses and result loads.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    commit     = 1'b0;
    push       = 1'b0;
    push_byte  = 8'h00;
    take       = 1'b0;
    issue      = 1'b0;
    copy_done  = 1'b0;
    flush_emit = 1'b0;
    out_load   = 1'b0;
    out_result = '{out_bytes: pack_word, byte_count: aldc_pkg::PACK_FULL,
                   run_last: 1'b0, stream_end: 1'b0, truncated: 1'b0};
    case (state)
      aldc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = aldc_pkg::ST_BITS;
        end
      end
      aldc_pkg::ST_BITS: begin
        if (!lit_done || can_take) begin
          commit = 1'b1;
          if (lit_done) begin
            push      = 1'b1;
            push_byte = field_next[7:0];
          end
          if (copy_go) begin
            state_next = aldc_pkg::ST_COPY;
          end else if (bit_idx == 3'd7) begin
            state_next = aldc_pkg::ST_FLUSH;
          end
        end
      end
      aldc_pkg::ST_COPY: begin
        take  = rd_pend && can_take;
        issue = (copy_rem != 9'd0) && (!rd_pend || can_take);
        if (take) begin
          push      = 1'b1;
          push_byte = copy_byte;
        end
        if ((copy_rem == 9'd0) && (!rd_pend || can_take)) begin
          copy_done  = 1'b1;
          state_next = (bit_idx == 3'd7) ? aldc_pkg::ST_FLUSH : aldc_pkg::ST_BITS;
        end
      end
      aldc_pkg::ST_FLUSH: begin
        flush_emit = (pack_cnt != 4'd0) || marker || last_q;
        if (!flush_emit) begin
          state_next = aldc_pkg::ST_IDLE;
        end else if (out_free) begin
          out_load   = 1'b1;
          out_result = '{out_bytes: pack_word, byte_count: pack_cnt, run_last: 1'b1,
                         stream_end: marker || last_q,
                         truncated: last_q && !ended && (phase != aldc_pkg::PH_FLAG)};
          state_next = aldc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = aldc_pkg::ST_IDLE;
      end
    endcase
    // A full group goes out only once a further byte shows it is not the last.
    if (push && (pack_cnt == aldc_pkg::PACK_FULL)) begin
      out_load = 1'b1;
    end
  end

  assign mem_we    = push;
  assign mem_waddr = wp;
  assign mem_wdata = push_byte;
  assign mem_re    = issue;
  assign mem_raddr = copy_src;

  // Entries beyond the fill point of this stream read as zero.
  assign unwritten = !wrapped && !(copy_src < wp) && !(push && (copy_src == wp));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aldc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= aldc_pkg::PH_FLAG;
      prefix    <= 3'd0;
      field     <= '0;
      bits_left <= 4'd0;
      copy_len  <= 9'd0;
      ended     <= 1'b0;
      marker    <= 1'b0;
      bit_idx   <= 3'd0;
      wp        <= '0;
      wrapped   <= 1'b0;
      copy_rem  <= 9'd0;
      rd_pend   <= 1'b0;
      pack_cnt  <= 4'd0;
      for (int i = 0; i < 8; i++) begin
        pack[i] <= 8'h00;
      end
    end else begin
      if ((state == aldc_pkg::ST_IDLE) && in_valid) begin
        byte_q  <= in_byte;
        last_q  <= in_last;
        bit_idx <= 3'd0;
        marker  <= 1'b0;
      end
      if (commit) begin
        phase     <= phase_next;
        prefix    <= prefix_next;
        field     <= field_next;
        bits_left <= bits_left_next;
        copy_len  <= copy_len_next;
        ended     <= ended_next;
        marker    <= marker_next;
        if (copy_go) begin
          copy_src <= shifted[WINDOW_BITS-1:0];
          copy_rem <= copy_len;
          rd_pend  <= 1'b0;
        end else begin
          bit_idx <= bit_idx + 3'd1;
        end
      end
      if (issue) begin
        copy_src <= copy_src + 1'b1;
        copy_rem <= copy_rem - 9'd1;
        rd_pend  <= 1'b1;
        rd_zero  <= unwritten;
      end else if (take) begin
        rd_pend <= 1'b0;
      end
      if (copy_done && (bit_idx != 3'd7)) begin
        bit_idx <= bit_idx + 3'd1;
      end
      if (push) begin
        wp <= wp + 1'b1;
        if (wp == '1) begin
          wrapped <= 1'b1;
        end
        if (pack_cnt == aldc_pkg::PACK_FULL) begin
          for (int i = 0; i < 8; i++) begin
            pack[i] <= (i == 0) ? push_byte : 8'h00;
          end
          pack_cnt <= 4'd1;
        end else begin
          pack[pack_cnt[2:0]] <= push_byte;
          pack_cnt            <= pack_cnt + 4'd1;
        end
      end
      if ((state == aldc_pkg::ST_FLUSH) && out_load) begin
        pack_cnt <= 4'd0;
        for (int i = 0; i < 8; i++) begin
          pack[i] <= 8'h00;
        end
        // The closing byte of a stream returns the parser and window to empty.
        if (last_q) begin
          phase     <= aldc_pkg::PH_FLAG;
          prefix    <= 3'd0;
          field     <= '0;
          bits_left <= 4'd0;
          copy_len  <= 9'd0;
          ended     <= 1'b0;
          wp        <= '0;
          wrapped   <= 1'b0;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (rst) out_load |-> out_free)
    else $error("result loaded while the output register is occupied");
  a_hold_read: assert property (@(posedge clk) disable iff (rst)
    (state == aldc_pkg::ST_COPY && rd_pend && !can_take) |-> !mem_re)
    else $error("window read issued over pending copy data");
  a_stream_reset: assert property (@(posedge clk) disable iff (rst)
    (state == aldc_pkg::ST_FLUSH && out_load && last_q) |=> (wp == '0 && !wrapped && !ended))
    else $error("stream state not cleared after the closing byte");
  a_pack_range: assert property (@(posedge clk) disable iff (rst)
    pack_cnt <= aldc_pkg::PACK_FULL)
    else $error("pack count beyond eight bytes");
`endif

endmodule

// ===== rtl/aldc_stream_decompressor.sv =====
// ALDC stream decompressor.
// Input channel s_*: one compressed byte per transaction, its bits parsed most
// significant first; s_tlast marks the final byte of a stream.
// Output channel m_*: up to eight decoded bytes per transaction, first byte in
// bits 7 to 0, with count, end and truncation flags in m_tuser; m_tlast marks
// the last result caused by an input byte.
// Each input byte is accepted, then parsed bit-serially by the token parser; a
// copy that completes in it (up to 286 bytes) is run before the next bit and
// starts with its first window read, and the byte ends with the flush of its
// final result. Copies read the history window memory at one byte per cycle
// unless a stalled receiver holds them; overlapping copies are forwarded from
// the write port. The next byte is taken once the flush has loaded the output
// register, even if that result has not yet been taken.
// When the receiver stalls, a full group of eight bytes that must leave for
// the next byte to be packed holds the parser and the copy until m_tready, and
// the flush of a final result waits until the output register is free.
// Reset (synchronous, rst high) empties the parser, the packer and the window
// fill point; the final byte of each stream does the same. Unwritten window
// entries read as zero, so no clearing pass is needed.
// Depends on aldc_pkg, aldc_window, aldc_decoder and aldc_outbuf.
module aldc_stream_decompressor #(
  parameter int WINDOW_BITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // comp_byte
  input  logic        s_tlast,   // stream_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // out_bytes
  output logic        m_tlast,   // run_last
  output logic [5:0]  m_tuser    // byte_count [3:0], stream_end [4], truncated [5]
);

  logic                   mem_we, mem_re;
  logic [WINDOW_BITS-1:0] mem_waddr, mem_raddr;
  logic [7:0]             mem_wdata, mem_rdata;
  logic                   out_free, out_load;
  aldc_pkg::result_t      out_result;

  aldc_window #(
    .WINDOW_BITS(WINDOW_BITS)
  ) u_window (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  aldc_decoder #(
    .WINDOW_BITS(WINDOW_BITS)
  ) u_decoder (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .in_last   (s_tlast),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .out_free  (out_free),
    .out_load  (out_load),
    .out_result(out_result)
  );

  aldc_outbuf u_outbuf (
    .clk     (clk),
    .rst     (rst),
    .load    (out_load),
    .result  (out_result),
    .free    (out_free),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
  );

endmodule
